// ===== rtl/cal_pkg.sv =====
// ----------------------------------------------------------------------------
// cal_pkg
// Shared types and request codes for the cursor array list.
// ----------------------------------------------------------------------------
`default_nettype none

package cal_pkg;

    // Default sizing
    localparam int CAPACITY_DEF   = 128;
    localparam int DATA_WIDTH_DEF = 32;

    // Request codes (11 to 15 behave as a no-op)
    localparam logic [3:0] REQ_NOP    = 4'd0;
    localparam logic [3:0] REQ_CLEAR  = 4'd1;
    localparam logic [3:0] REQ_INSERT = 4'd2;
    localparam logic [3:0] REQ_APPEND = 4'd3;
    localparam logic [3:0] REQ_START  = 4'd4;
    localparam logic [3:0] REQ_END    = 4'd5;
    localparam logic [3:0] REQ_PREV   = 4'd6;
    localparam logic [3:0] REQ_NEXT   = 4'd7;
    localparam logic [3:0] REQ_MOVETO = 4'd8;
    localparam logic [3:0] REQ_SET    = 4'd9;
    localparam logic [3:0] REQ_REMOVE = 4'd10;

    // Request transaction
    typedef struct packed {
        logic [3:0]  req_type;
        logic [6:0]  position;
        logic [31:0] item_value;
    } cal_req_t;

    // Result transaction
    typedef struct packed {
        logic [31:0] result_value;
        logic [7:0]  list_length;
        logic [7:0]  cursor_pos;
        logic        error_flag;
    } cal_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/cursor_array_list.sv =====
// Each request is accepted and executed; all but remove then read back the entry at the cursor
// (zero if the cursor is at the list end), an insert inside the list first shifting the tail up.
// A remove returns the removed entry and shifts the tail down; a refused one returns zero.
// A result held by back-pressure adds its stall. One request at a time; s_ready high when idle.
// Reset (aresetn low, synchronous) clears count, cursor and the handshake state;
// stored entries are not cleared and are never reported before being written.
// ----------------------------------------------------------------------------
// cursor_array_list
// Bounded ordered list with a cursor, held in a single-port-pair RAM and
// walked by a small sequencer that shifts entries one per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module cursor_array_list
    import cal_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire cal_req_t s_data,
    output logic          m_valid,
    input  wire logic     m_ready,
    output cal_rsp_t      m_data
);

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int CMP_W  = (CNT_W > 7) ? CNT_W : 7;

    typedef enum logic [3:0] {
        S_IDLE, S_EXEC, S_SHUP, S_PUT, S_RMHD, S_SHDN, S_RD, S_RDW, S_DONE
    } state_t;

    state_t                state_reg;
    logic [3:0]            req_reg;
    logic [6:0]            pos_reg;
    logic [DATA_WIDTH-1:0] val_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      cursor_reg;
    logic [CNT_W-1:0]      idx_reg;
    logic [DATA_WIDTH-1:0] res_reg;
    logic                  err_reg;
    logic                  m_valid_reg;
    cal_rsp_t              m_data_reg;

    logic                  mem_we;
    logic [ADDR_W-1:0]     mem_waddr;
    logic [DATA_WIDTH-1:0] mem_wdata;
    logic [ADDR_W-1:0]     mem_raddr;
    logic [DATA_WIDTH-1:0] mem_rdata;

    logic                  is_full;
    logic                  at_end;
    logic                  set_oob;
    logic                  pos_ok;
    logic                  shup_more;
    logic                  rm_more;
    logic                  shdn_more;
    logic [CNT_W-1:0]      idx_m1;
    logic [CNT_W-1:0]      idx_m2;
    logic [CNT_W:0]        idx_p2;
    logic [CNT_W:0]        cur_p1;
    logic [CNT_W-1:0]      cnt_m1;
    logic [63:0]           in_wide;
    logic [63:0]           res_wide;
    logic [15:0]           cnt_wide;
    logic [15:0]           cur_wide;

    // Condition flags
    assign is_full   = (count_reg == CNT_W'(CAPACITY));
    assign at_end    = (cursor_reg == count_reg);
    assign set_oob   = (cursor_reg == CNT_W'(CAPACITY));
    assign pos_ok    = (CMP_W'(pos_reg) < CMP_W'(count_reg));
    assign idx_m1    = idx_reg - CNT_W'(1);
    assign idx_m2    = idx_reg - CNT_W'(2);
    assign idx_p2    = (CNT_W + 1)'(idx_reg) + (CNT_W + 1)'(2);
    assign cur_p1    = (CNT_W + 1)'(cursor_reg) + (CNT_W + 1)'(1);
    assign cnt_m1    = count_reg - CNT_W'(1);
    assign shup_more = (idx_m1 > cursor_reg);
    assign rm_more   = (cur_p1 < (CNT_W + 1)'(count_reg));
    assign shdn_more = (idx_p2 < (CNT_W + 1)'(count_reg));

    // Data width adaption
    assign in_wide  = {32'd0, s_data.item_value};
    assign res_wide = 64'(res_reg);
    assign cnt_wide = 16'(count_reg);
    assign cur_wide = 16'(cursor_reg);

    // Entry store port control
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = cursor_reg[ADDR_W-1:0];
        mem_wdata = val_reg;
        mem_raddr = cursor_reg[ADDR_W-1:0];
        case (state_reg)
            S_EXEC: begin
                case (req_reg)
                    REQ_INSERT: begin
                        if (!is_full && at_end) begin
                            mem_we = 1'b1;
                        end
                        mem_raddr = cnt_m1[ADDR_W-1:0];
                    end
                    REQ_APPEND: begin
                        mem_we    = !is_full;
                        mem_waddr = count_reg[ADDR_W-1:0];
                    end
                    REQ_SET: begin
                        mem_we = !set_oob;
                    end
                    default: begin
                    end
                endcase
            end
            S_SHUP: begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg[ADDR_W-1:0];
                mem_wdata = mem_rdata;
                mem_raddr = idx_m2[ADDR_W-1:0];
            end
            S_PUT: begin
                mem_we = 1'b1;
            end
            S_RMHD: begin
                mem_raddr = cur_p1[ADDR_W-1:0];
            end
            S_SHDN: begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg[ADDR_W-1:0];
                mem_wdata = mem_rdata;
                mem_raddr = idx_p2[ADDR_W-1:0];
            end
            default: begin
            end
        endcase
    end

    // Sequencer with registered result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            cursor_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && state_reg != S_DONE) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        req_reg   <= s_data.req_type;
                        pos_reg   <= s_data.position;
                        val_reg   <= DATA_WIDTH'(in_wide);
                        err_reg   <= 1'b0;
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    case (req_reg)
                        REQ_CLEAR: begin
                            count_reg  <= '0;
                            cursor_reg <= '0;
                            state_reg  <= S_RD;
                        end
                        REQ_INSERT: begin
                            if (is_full) begin
                                err_reg   <= 1'b1;
                                state_reg <= S_RD;
                            end else if (at_end) begin
                                count_reg <= count_reg + CNT_W'(1);
                                state_reg <= S_RD;
                            end else begin
                                idx_reg   <= count_reg;
                                state_reg <= S_SHUP;
                            end
                        end
                        REQ_APPEND: begin
                            if (is_full) begin
                                err_reg <= 1'b1;
                            end else begin
                                count_reg <= count_reg + CNT_W'(1);
                            end
                            state_reg <= S_RD;
                        end
                        REQ_START: begin
                            cursor_reg <= '0;
                            state_reg  <= S_RD;
                        end
                        REQ_END: begin
                            cursor_reg <= count_reg;
                            state_reg  <= S_RD;
                        end
                        REQ_PREV: begin
                            if (cursor_reg != '0) begin
                                cursor_reg <= cursor_reg - CNT_W'(1);
                            end
                            state_reg <= S_RD;
                        end
                        REQ_NEXT: begin
                            if (!at_end) begin
                                cursor_reg <= cursor_reg + CNT_W'(1);
                            end
                            state_reg <= S_RD;
                        end
                        REQ_MOVETO: begin
                            if (pos_ok) begin
                                cursor_reg <= CNT_W'(pos_reg);
                            end
                            state_reg <= S_RD;
                        end
                        REQ_SET: begin
                            err_reg   <= set_oob;
                            state_reg <= S_RD;
                        end
                        REQ_REMOVE: begin
                            if (at_end) begin
                                err_reg   <= 1'b1;
                                res_reg   <= '0;
                                state_reg <= S_DONE;
                            end else begin
                                state_reg <= S_RMHD;
                            end
                        end
                        default: begin
                            state_reg <= S_RD;
                        end
                    endcase
                end
                // Shift up: entry idx-1 moves to idx, one per cycle
                S_SHUP: begin
                    idx_reg <= idx_m1;
                    if (!shup_more) begin
                        state_reg <= S_PUT;
                    end
                end
                S_PUT: begin
                    count_reg <= count_reg + CNT_W'(1);
                    state_reg <= S_RD;
                end
                // Removed entry arrives; start the shift down if needed
                S_RMHD: begin
                    res_reg <= mem_rdata;
                    idx_reg <= cursor_reg;
                    if (rm_more) begin
                        state_reg <= S_SHDN;
                    end else begin
                        count_reg <= cnt_m1;
                        state_reg <= S_DONE;
                    end
                end
                // Shift down: entry idx+1 moves to idx, one per cycle
                S_SHDN: begin
                    idx_reg <= idx_reg + CNT_W'(1);
                    if (!shdn_more) begin
                        count_reg <= cnt_m1;
                        state_reg <= S_DONE;
                    end
                end
                S_RD: begin
                    if (at_end) begin
                        res_reg   <= '0;
                        state_reg <= S_DONE;
                    end else begin
                        state_reg <= S_RDW;
                    end
                end
                S_RDW: begin
                    res_reg   <= mem_rdata;
                    state_reg <= S_DONE;
                end
                S_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg             <= 1'b1;
                        m_data_reg.result_value <= res_wide[31:0];
                        m_data_reg.list_length  <= cnt_wide[7:0];
                        m_data_reg.cursor_pos   <= cur_wide[7:0];
                        m_data_reg.error_flag   <= err_reg;
                        state_reg               <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    cal_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (DATA_WIDTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Checks
    a_cursor_in_list: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> (cursor_reg <= count_reg))
        else $error("cursor beyond list length");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("count beyond capacity");

    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("sequencer did not leave idle after accept");

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result raised outside the completion step");

    a_no_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (state_reg != S_IDLE && state_reg != S_DONE))
        else $error("entry store written while not processing");

endmodule

`default_nettype wire

// ===== rtl/cal_ram.sv =====
// ----------------------------------------------------------------------------
// cal_ram
// Entry store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cal_ram #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, old data on a same-cycle collision
    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire
